>>> design/illl_pkg.sv
`default_nettype none

package illl_pkg;

  localparam int unsigned DEF_CAPACITY   = 256;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic        [2:0]  opcode;
    logic        [8:0]  position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [8:0]  length;
    logic signed [31:0] first_value;
    logic signed [31:0] last_value;
  } out_t;

endpackage

`default_nettype wire

>>> design/illl_ram.sv
`default_nettype none

module illl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds its value between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/indexed_linked_list_engine_top.sv
`default_nettype none

// Bounded list of signed values held as a singly linked chain of slots in a
// data memory and a next-pointer memory, with a stack memory of recycled
// slots (never-used slots come from a fill counter, so no clearing pass is
// needed after reset). One operation is taken at a time and gives one
// result. Pop back, insert and erase may walk the chain from the head, one
// next-pointer memory read per cycle. A finished result sits in an output
// register, so the next operation is taken while it waits.
module indexed_linked_list_engine_top #(
  parameter int unsigned CAPACITY   = illl_pkg::DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = illl_pkg::DEF_DATA_WIDTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire illl_pkg::in_t in_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output illl_pkg::out_t     out_o
);

  localparam int unsigned SW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] NIL = CW'(CAPACITY);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_EXEC  = 10'b00_0000_0010,
    S_WALK  = 10'b00_0000_0100,
    S_INS   = 10'b00_0000_1000,
    S_LINK  = 10'b00_0001_0000,
    S_POPB  = 10'b00_0010_0000,
    S_ERA1  = 10'b00_0100_0000,
    S_ERA2  = 10'b00_1000_0000,
    S_FETCH = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  function automatic logic [SW-1:0] slot_addr(logic [CW-1:0] s);
    return (s < NIL) ? s[SW-1:0] : '0;
  endfunction

  state_e state_q, state_d;

  logic [CW-1:0] head_q, head_d, tail_q, tail_d, len_q, len_d;
  logic [CW-1:0] fresh_q, fresh_d, rec_q, rec_d;
  logic          out_valid_q, out_valid_d;

  logic [2:0]            op_q, op_d;
  logic [8:0]            pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [DATA_WIDTH-1:0] head_val_q, head_val_d, tail_val_q, tail_val_d;
  logic [SW-1:0]         slot_q, slot_d, prev_q, prev_d, t_q, t_d;
  logic [SW-1:0]         link_addr_q, link_addr_d, link_val_q, link_val_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic                  fetch_tail_q, fetch_tail_d;
  illl_pkg::status_e     status_q, status_d;
  illl_pkg::out_t        out_q, out_d;

  // memory ports
  logic                  d_we, d_re, n_we, n_re, f_we, f_re;
  logic [SW-1:0]         d_waddr, d_raddr, n_waddr, n_raddr, f_waddr, f_raddr;
  logic [DATA_WIDTH-1:0] d_wdata, d_rdata;
  logic [CW-1:0]         n_wdata, n_rdata;
  logic [SW-1:0]         f_wdata, f_rdata;

  // decode of the operation in the execute cycle
  logic          full, empty;
  logic [SW-1:0] new_slot;
  logic [CMPW-1:0] pos_w, len_w;
  logic [CW-1:0] rec_m1, walk_n;
  logic          do_pf, do_pb, do_df, do_walk, alloc_mid, walk_done;
  logic [SW-1:0] walk_prev;

  illl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  illl_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (n_re),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  illl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  assign full     = (len_q == NIL);
  assign empty    = (len_q == '0);
  assign new_slot = (rec_q != '0) ? f_rdata : fresh_q[SW-1:0];
  assign pos_w    = CMPW'(pos_q);
  assign len_w    = CMPW'(len_q);
  assign rec_m1   = rec_q - CW'(1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    len_d        = len_q;
    fresh_d      = fresh_q;
    rec_d        = rec_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    pos_d        = pos_q;
    val_d        = val_q;
    head_val_d   = head_val_q;
    tail_val_d   = tail_val_q;
    slot_d       = slot_q;
    prev_d       = prev_q;
    t_d          = t_q;
    link_addr_d  = link_addr_q;
    link_val_d   = link_val_q;
    rem_d        = rem_q;
    fetch_tail_d = fetch_tail_q;
    status_d     = status_q;
    out_d        = out_q;

    d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_re = 1'b0; d_raddr = '0;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_re = 1'b0; n_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;

    do_pf     = 1'b0;
    do_pb     = 1'b0;
    do_df     = 1'b0;
    do_walk   = 1'b0;
    alloc_mid = 1'b0;
    walk_n    = '0;
    walk_done = 1'b0;
    walk_prev = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_i.opcode;
          pos_d   = in_i.position;
          val_d   = DATA_WIDTH'($unsigned(in_i.value));
          // top of the recycled stack and the head's successor, both speculative
          f_re    = 1'b1;
          f_raddr = rec_m1[SW-1:0];
          n_re    = 1'b1;
          n_raddr = slot_addr(head_q);
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        status_d = illl_pkg::STATUS_OK;
        state_d  = S_DONE;
        unique case (illl_pkg::op_e'(op_q))
          illl_pkg::OP_PUSH_FRONT: begin
            if (full) status_d = illl_pkg::STATUS_FULL;
            else      do_pf = 1'b1;
          end
          illl_pkg::OP_PUSH_BACK: begin
            if (full) status_d = illl_pkg::STATUS_FULL;
            else      do_pb = 1'b1;
          end
          illl_pkg::OP_POP_FRONT: begin
            if (empty) status_d = illl_pkg::STATUS_EMPTY;
            else       do_df = 1'b1;
          end
          illl_pkg::OP_POP_BACK: begin
            if (empty) begin
              status_d = illl_pkg::STATUS_EMPTY;
            end else if (len_q == CW'(1)) begin
              do_df = 1'b1;
            end else begin
              do_walk = 1'b1;
              walk_n  = len_q - CW'(2);
            end
          end
          illl_pkg::OP_INSERT: begin
            priority if (pos_w > len_w) begin
              status_d = illl_pkg::STATUS_RANGE;
            end else if (full) begin
              status_d = illl_pkg::STATUS_FULL;
            end else if (pos_q == '0) begin
              do_pf = 1'b1;
            end else if (pos_w == len_w) begin
              do_pb = 1'b1;
            end else begin
              alloc_mid = 1'b1;
              do_walk   = 1'b1;
              walk_n    = CW'(pos_q) - CW'(1);
            end
          end
          illl_pkg::OP_ERASE: begin
            priority if (empty) begin
              status_d = illl_pkg::STATUS_EMPTY;
            end else if (pos_w >= len_w) begin
              status_d = illl_pkg::STATUS_RANGE;
            end else if (pos_q == '0) begin
              do_df = 1'b1;
            end else begin
              do_walk = 1'b1;
              walk_n  = CW'(pos_q) - CW'(1);
            end
          end
          default: ;
        endcase

        if (do_pf || do_pb || alloc_mid) begin
          if (rec_q != '0) rec_d = rec_q - CW'(1);
          else             fresh_d = fresh_q + CW'(1);
        end

        if (do_pf) begin
          d_we       = 1'b1;
          d_waddr    = new_slot;
          d_wdata    = val_q;
          n_we       = 1'b1;
          n_waddr    = new_slot;
          n_wdata    = head_q;
          head_d     = CW'(new_slot);
          head_val_d = val_q;
          if (tail_q == NIL) begin
            tail_d     = CW'(new_slot);
            tail_val_d = val_q;
          end
          len_d = len_q + CW'(1);
        end

        if (do_pb) begin
          d_we       = 1'b1;
          d_waddr    = new_slot;
          d_wdata    = val_q;
          n_we       = 1'b1;
          n_waddr    = new_slot;
          n_wdata    = NIL;
          tail_d     = CW'(new_slot);
          tail_val_d = val_q;
          len_d      = len_q + CW'(1);
          if (head_q == NIL) begin
            head_d     = CW'(new_slot);
            head_val_d = val_q;
          end else begin
            // old tail gets linked in the next cycle
            link_addr_d = slot_addr(tail_q);
            link_val_d  = new_slot;
            state_d     = S_LINK;
          end
        end

        if (do_df) begin
          head_d  = n_rdata;
          if (n_rdata == NIL) tail_d = NIL;
          f_we    = 1'b1;
          f_waddr = rec_q[SW-1:0];
          f_wdata = slot_addr(head_q);
          rec_d   = rec_q + CW'(1);
          len_d   = len_q - CW'(1);
          if (n_rdata != NIL) begin
            d_re         = 1'b1;
            d_raddr      = slot_addr(n_rdata);
            fetch_tail_d = 1'b0;
            state_d      = S_FETCH;
          end
        end

        if (alloc_mid) begin
          slot_d = new_slot;
        end

        if (do_walk) begin
          priority if (walk_n == '0) begin
            walk_done = 1'b1;
            walk_prev = slot_addr(head_q);
          end else if (walk_n == CW'(1)) begin
            walk_done = 1'b1;
            walk_prev = slot_addr(n_rdata);
          end else begin
            n_re    = 1'b1;
            n_raddr = slot_addr(n_rdata);
            rem_d   = walk_n - CW'(1);
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (rem_q == CW'(1)) begin
          walk_done = 1'b1;
          walk_prev = slot_addr(n_rdata);
        end else begin
          n_re    = 1'b1;
          n_raddr = slot_addr(n_rdata);
          rem_d   = rem_q - CW'(1);
        end
      end

      S_POPB: begin
        f_we         = 1'b1;
        f_waddr      = rec_q[SW-1:0];
        f_wdata      = slot_addr(tail_q);
        rec_d        = rec_q + CW'(1);
        n_we         = 1'b1;
        n_waddr      = prev_q;
        n_wdata      = NIL;
        tail_d       = CW'(prev_q);
        len_d        = len_q - CW'(1);
        d_re         = 1'b1;
        d_raddr      = prev_q;
        fetch_tail_d = 1'b1;
        state_d      = S_FETCH;
      end

      S_INS: begin
        // read data holds next of the node before the insertion point
        d_we        = 1'b1;
        d_waddr     = slot_q;
        d_wdata     = val_q;
        n_we        = 1'b1;
        n_waddr     = slot_q;
        n_wdata     = n_rdata;
        link_addr_d = prev_q;
        link_val_d  = slot_q;
        len_d       = len_q + CW'(1);
        state_d     = S_LINK;
      end

      S_LINK: begin
        n_we    = 1'b1;
        n_waddr = link_addr_q;
        n_wdata = CW'(link_val_q);
        state_d = S_DONE;
      end

      S_ERA1: begin
        t_d     = slot_addr(n_rdata);
        n_re    = 1'b1;
        n_raddr = slot_addr(n_rdata);
        state_d = S_ERA2;
      end

      S_ERA2: begin
        n_we    = 1'b1;
        n_waddr = prev_q;
        n_wdata = n_rdata;
        f_we    = 1'b1;
        f_waddr = rec_q[SW-1:0];
        f_wdata = t_q;
        rec_d   = rec_q + CW'(1);
        len_d   = len_q - CW'(1);
        if (CW'(t_q) == tail_q) begin
          tail_d       = CW'(prev_q);
          d_re         = 1'b1;
          d_raddr      = prev_q;
          fetch_tail_d = 1'b1;
          state_d      = S_FETCH;
        end else begin
          state_d = S_DONE;
        end
      end

      S_FETCH: begin
        if (fetch_tail_q) tail_val_d = d_rdata;
        else              head_val_d = d_rdata;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status = status_q;
          out_d.length = 9'(len_q);
          if (len_q == '0) begin
            out_d.first_value = '0;
            out_d.last_value  = '0;
          end else begin
            out_d.first_value = 32'(head_val_q);
            out_d.last_value  = 32'(tail_val_q);
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // end of a walk: fetch next of the found node and branch on the operation
    if (walk_done) begin
      prev_d  = walk_prev;
      n_re    = 1'b1;
      n_raddr = walk_prev;
      priority if (illl_pkg::op_e'(op_q) == illl_pkg::OP_POP_BACK) begin
        state_d = S_POPB;
      end else if (illl_pkg::op_e'(op_q) == illl_pkg::OP_INSERT) begin
        state_d = S_INS;
      end else begin
        state_d = S_ERA1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NIL;
      tail_q      <= NIL;
      len_q       <= '0;
      fresh_q     <= '0;
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      len_q       <= len_d;
      fresh_q     <= fresh_d;
      rec_q       <= rec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    head_val_q   <= head_val_d;
    tail_val_q   <= tail_val_d;
    slot_q       <= slot_d;
    prev_q       <= prev_d;
    t_q          <= t_d;
    link_addr_q  <= link_addr_d;
    link_val_q   <= link_val_d;
    rem_q        <= rem_d;
    fetch_tail_q <= fetch_tail_d;
    status_q     <= status_d;
    out_q        <= out_d;
  end

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;

  localparam int unsigned CAP = illl_pkg::DEF_CAPACITY;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT_CYCLES = 300;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  illl_pkg::in_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  illl_pkg::out_t out_o;

  // shadow copy of the list contents, head at index 0
  logic signed [31:0] shadow_list[$];
  illl_pkg::out_t pending_reports[$];
  illl_pkg::out_t oldest_report;
  int unsigned mismatch_count = 0;
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;

  indexed_linked_list_engine_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_i(in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o(out_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic illl_pkg::out_t apply_list_op(illl_pkg::in_t op_item);
    illl_pkg::out_t rep;
    int unsigned len;
    int unsigned pos;
    len = shadow_list.size();
    pos = int'(op_item.position);
    rep = '0;
    rep.status = illl_pkg::STATUS_OK;
    unique case (op_item.opcode)
      illl_pkg::OP_PUSH_FRONT: begin
        if (len == CAP) rep.status = illl_pkg::STATUS_FULL;
        else shadow_list.insert(0, op_item.value);
      end
      illl_pkg::OP_PUSH_BACK: begin
        if (len == CAP) rep.status = illl_pkg::STATUS_FULL;
        else shadow_list.insert(len, op_item.value);
      end
      illl_pkg::OP_POP_FRONT: begin
        if (len == 0) rep.status = illl_pkg::STATUS_EMPTY;
        else shadow_list.delete(0);
      end
      illl_pkg::OP_POP_BACK: begin
        if (len == 0) rep.status = illl_pkg::STATUS_EMPTY;
        else shadow_list.delete(len - 1);
      end
      illl_pkg::OP_INSERT: begin
        // range is checked before fullness
        if (pos > len) rep.status = illl_pkg::STATUS_RANGE;
        else if (len == CAP) rep.status = illl_pkg::STATUS_FULL;
        else shadow_list.insert(pos, op_item.value);
      end
      illl_pkg::OP_ERASE: begin
        if (len == 0) rep.status = illl_pkg::STATUS_EMPTY;
        else if (pos >= len) rep.status = illl_pkg::STATUS_RANGE;
        else shadow_list.delete(pos);
      end
      default: ;
    endcase
    rep.length = 9'(shadow_list.size());
    if (shadow_list.size() != 0) begin
      rep.first_value = shadow_list[0];
      rep.last_value = shadow_list[$];
    end
    return rep;
  endfunction

  function automatic logic [31:0] pick_value();
    unique case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // offer one operation and hold it until the transfer happens
  task automatic send_op(logic [2:0] op, logic [8:0] pos, logic [31:0] val);
    illl_pkg::in_t op_item;
    op_item.opcode = op;
    op_item.position = pos;
    op_item.value = val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= op_item;
    do @(posedge clk_i); while (in_stall_o);
    pending_reports.insert(pending_reports.size(), apply_list_op(op_item));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // well-formed operation, grow_pct sets the chance of adding an element
  task automatic send_shaped(int unsigned grow_pct);
    int unsigned len;
    len = shadow_list.size();
    if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0: send_op(illl_pkg::OP_PUSH_FRONT, 9'($urandom_range(0, 511)), pick_value());
        1: send_op(illl_pkg::OP_PUSH_BACK, 9'($urandom_range(0, 511)), pick_value());
        default: send_op(illl_pkg::OP_INSERT, 9'($urandom_range(0, len)), pick_value());
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: send_op(illl_pkg::OP_POP_FRONT, 9'($urandom_range(0, 511)), pick_value());
        1: send_op(illl_pkg::OP_POP_BACK, 9'($urandom_range(0, 511)), pick_value());
        default: send_op(illl_pkg::OP_ERASE,
                         9'(len == 0 ? 0 : $urandom_range(0, len - 1)), pick_value());
      endcase
    end
  endtask

  task automatic send_noise();
    send_op(3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)), pick_value());
  endtask

  task automatic test_edge_cases();
    send_op(illl_pkg::OP_POP_FRONT, 9'd0, 32'h0);
    send_op(illl_pkg::OP_POP_BACK, 9'd0, 32'h0);
    send_op(illl_pkg::OP_ERASE, 9'd0, 32'h0);
    send_op(illl_pkg::OP_ERASE, 9'd511, 32'hffff_ffff);
    send_op(illl_pkg::OP_INSERT, 9'd1, 32'h1234_5678);
    send_op(illl_pkg::OP_INSERT, 9'd511, 32'h1234_5678);
    // insert at zero on an empty list must set the tail as well
    send_op(illl_pkg::OP_INSERT, 9'd0, 32'h7fff_ffff);
    send_op(illl_pkg::OP_PUSH_BACK, 9'd0, 32'h8000_0000);
    send_op(illl_pkg::OP_PUSH_FRONT, 9'd0, 32'hffff_ffff);
    send_op(illl_pkg::OP_PUSH_BACK, 9'd0, 32'h0);
    send_op(illl_pkg::OP_INSERT, 9'd2, 32'h5555_5555);
    send_op(illl_pkg::OP_INSERT, 9'd5, 32'haaaa_aaaa);
    send_op(illl_pkg::OP_INSERT, 9'd7, 32'h1);
    send_op(illl_pkg::OP_ERASE, 9'd6, 32'h0);
    send_op(illl_pkg::OP_ERASE, 9'd256, 32'h0);
    send_op(illl_pkg::OP_ERASE, 9'd5, 32'h0);
    send_op(illl_pkg::OP_ERASE, 9'd2, 32'h0);
    send_op(illl_pkg::OP_ERASE, 9'd0, 32'h0);
    send_op(OP_SPARE_6, 9'd0, 32'h0);
    send_op(OP_SPARE_7, 9'd511, 32'haaaa_aaaa);
    send_op(illl_pkg::OP_POP_BACK, 9'd0, 32'h0);
    send_op(illl_pkg::OP_POP_FRONT, 9'd0, 32'h0);
    send_op(illl_pkg::OP_POP_BACK, 9'd0, 32'h0);
    send_op(OP_SPARE_7, 9'd0, 32'h0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (12) send_shaped(70);
    wait_drained();
  endtask

  task automatic test_fill_to_capacity();
    while (shadow_list.size() < CAP) send_shaped(94);
    send_op(illl_pkg::OP_PUSH_FRONT, 9'd0, pick_value());
    send_op(illl_pkg::OP_PUSH_BACK, 9'd0, pick_value());
    send_op(illl_pkg::OP_INSERT, 9'd0, pick_value());
    send_op(illl_pkg::OP_INSERT, 9'd128, pick_value());
    send_op(illl_pkg::OP_INSERT, 9'd256, pick_value());
    send_op(illl_pkg::OP_INSERT, 9'd257, pick_value());
    send_op(illl_pkg::OP_INSERT, 9'd511, pick_value());
    send_op(illl_pkg::OP_ERASE, 9'd256, 32'h0);
    send_op(illl_pkg::OP_ERASE, 9'd255, 32'h0);
    send_op(illl_pkg::OP_INSERT, 9'd200, pick_value());
    send_op(illl_pkg::OP_POP_BACK, 9'd0, 32'h0);
    send_op(illl_pkg::OP_PUSH_BACK, 9'd0, pick_value());
    wait_drained();
  endtask

  task automatic test_drain();
    while (shadow_list.size() != 0) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_shaped(8);
    end
    wait_drained();
  endtask

  task automatic test_random_mix(int unsigned blocks);
    int unsigned grow_pct;
    repeat (blocks) begin
      idle_on = ($urandom_range(0, 3) != 0);
      grow_pct = $urandom_range(20, 80);
      repeat (50) begin
        if ($urandom_range(0, 9) < 3) send_noise();
        else send_shaped(grow_pct);
      end
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_no_idling();
    idle_on = 1'b0;
    repeat (100) begin
      if ($urandom_range(0, 9) < 2) send_noise();
      else send_shaped(55);
    end
    wait_drained();
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with no operation outstanding");
        mismatch_count++;
      end else begin
        oldest_report = pending_reports[0];
        pending_reports.delete(0);
        if (out_o.status !== oldest_report.status) begin
          $error("status: expected %0d, got %0d", oldest_report.status, out_o.status);
          mismatch_count++;
        end
        if (out_o.length !== oldest_report.length) begin
          $error("length: expected %0d, got %0d", oldest_report.length, out_o.length);
          mismatch_count++;
        end
        if (out_o.first_value !== oldest_report.first_value) begin
          $error("first_value: expected %0d, got %0d", oldest_report.first_value,
                 out_o.first_value);
          mismatch_count++;
        end
        if (out_o.last_value !== oldest_report.last_value) begin
          $error("last_value: expected %0d, got %0d", oldest_report.last_value,
                 out_o.last_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    test_backpressure();
    test_fill_to_capacity();
    test_drain();
    test_random_mix(14);
    test_no_idling();
    // nothing may show up once every operation has reported
    repeat (DRAIN_WAIT_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/illl_pkg.sv
design/illl_ram.sv
design/indexed_linked_list_engine_top.sv
test/tb.sv
